FILE: rtl/core/signed_vector_angle_unit_assert.svh
// Assertion macros for the angle unit RTL.
`ifndef SIGNED_VECTOR_ANGLE_UNIT_ASSERT_SVH
`define SIGNED_VECTOR_ANGLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVA_ASSERT_NOW(name, clk_i, rst_ni, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("signed_vector_angle_unit: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SVA_ASSERT_NEXT(name, clk_i, rst_ni, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("signed_vector_angle_unit: assertion failed");

`endif

FILE: rtl/core/sva_pkg.sv
package sva_pkg;

	// Internal datapath widths (cover component widths up to 32 bits)
	localparam int XW = 36;
	localparam int ZW = 36;
	localparam int MW = 33;
	localparam int MAG_TOP = 31;
	localparam int NORM_STEPS = 5;

	// Angle constants, Q.30 and Q2.13
	localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [ZW-1:0] TWO_PI_Q30 = 36'sd6746518852;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [ZW-1:0] ROUND_HALF = 36'sd65536;
	localparam int FRAC_DROP = 17;
	localparam logic signed [15:0] PI_Q13 = 16'sd25736;
	localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
	localparam logic [14:0] PI_Q13_MAG = 15'd25736;

	// One vector in flight: components, angle accumulator, larger magnitude
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic [MW-1:0] m;
	} vec_t;

	// One beat moving down the row of cells
	typedef struct packed {
		logic valid;
		logic neg;
		logic zero;
		vec_t a;
		vec_t b;
	} beat_t;

	// atan(2^-i) in Q.30
	function automatic logic signed [ZW-1:0] atan_q30(input int unsigned idx);
		logic signed [ZW-1:0] r;
		begin
			case (idx)
				0: r = 36'sd843314857;
				1: r = 36'sd497837829;
				2: r = 36'sd263043837;
				3: r = 36'sd133525159;
				4: r = 36'sd67021687;
				5: r = 36'sd33543516;
				6: r = 36'sd16775851;
				7: r = 36'sd8388437;
				8: r = 36'sd4194283;
				9: r = 36'sd2097149;
				10: r = 36'sd1048576;
				11: r = 36'sd524288;
				12: r = 36'sd262144;
				13: r = 36'sd131072;
				14: r = 36'sd65536;
				15: r = 36'sd32768;
				16: r = 36'sd16384;
				17: r = 36'sd8192;
				18: r = 36'sd4096;
				19: r = 36'sd2048;
				20: r = 36'sd1024;
				21: r = 36'sd512;
				22: r = 36'sd256;
				23: r = 36'sd128;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

FILE: rtl/core/sva_vec_if.sv
interface sva_vec_if #(
	parameter int COMPONENT_WIDTH = 16
);
	logic valid;
	logic ready;
	logic signed [COMPONENT_WIDTH-1:0] first_x;
	logic signed [COMPONENT_WIDTH-1:0] first_y;
	logic signed [COMPONENT_WIDTH-1:0] second_x;
	logic signed [COMPONENT_WIDTH-1:0] second_y;

	modport source (output valid, first_x, first_y, second_x, second_y, input ready);
	modport sink (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

FILE: rtl/core/sva_res_if.sv
interface sva_res_if;
	logic valid;
	logic ready;
	logic signed [15:0] angle_rad;
	logic zero_vector;

	modport source (output valid, angle_rad, zero_vector, input ready);
	modport sink (input valid, angle_rad, zero_vector, output ready);
endinterface

FILE: rtl/core/sva_cfg_if.sv
interface sva_cfg_if;
	logic valid;
	logic ready;
	logic fold_mode;

	modport source (output valid, fold_mode, input ready);
	modport sink (input valid, fold_mode, output ready);
endinterface

FILE: rtl/core/sva_norm_cell.sv
module sva_norm_cell #(
	parameter int SHIFT = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sva_pkg::beat_t prev,
	input  logic          hold_next,
	output sva_pkg::beat_t beat,
	output logic          hold
);

	sva_pkg::beat_t data_s1;
	sva_pkg::beat_t data_d;
	logic valid_s1;

	// Double a vector SHIFT times when its larger magnitude stays below 2^31
	function automatic sva_pkg::vec_t scale(input sva_pkg::vec_t v);
		sva_pkg::vec_t r;
		begin
			r = v;
			if ((v.m >> (sva_pkg::MAG_TOP - SHIFT)) == '0) begin
				r.x = v.x <<< SHIFT;
				r.y = v.y <<< SHIFT;
				r.m = v.m << SHIFT;
			end
			return r;
		end
	endfunction

	// Hold while this beat and everything downstream is stalled
	assign hold = valid_s1 && hold_next;

	// Advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold) begin
			valid_s1 <= prev.valid;
		end
	end

	// Scale both vectors ahead of the payload register
	always_comb begin
		data_d = prev;
		data_d.a = scale(prev.a);
		data_d.b = scale(prev.b);
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (!hold) begin
			data_s1 <= data_d;
		end
	end

	always_comb begin
		beat = data_s1;
		beat.valid = valid_s1;
	end

endmodule

FILE: rtl/core/sva_cordic_cell.sv
module sva_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sva_pkg::beat_t prev,
	input  logic          hold_next,
	output sva_pkg::beat_t beat,
	output logic          hold
);

	sva_pkg::beat_t data_s1;
	sva_pkg::beat_t data_d;
	logic valid_s1;

	// One vectoring micro-rotation, driving y toward zero
	function automatic sva_pkg::vec_t rotate(input sva_pkg::vec_t v);
		sva_pkg::vec_t r;
		logic signed [sva_pkg::XW-1:0] xs;
		logic signed [sva_pkg::XW-1:0] ys;
		begin
			r = v;
			xs = $signed(v.x) >>> STAGE;
			ys = $signed(v.y) >>> STAGE;
			if (!v.y[sva_pkg::XW-1]) begin
				r.x = v.x + ys;
				r.y = v.y - xs;
				r.z = v.z + sva_pkg::atan_q30(STAGE);
			end else begin
				r.x = v.x - ys;
				r.y = v.y + xs;
				r.z = v.z - sva_pkg::atan_q30(STAGE);
			end
			return r;
		end
	endfunction

	// Hold while this beat and everything downstream is stalled
	assign hold = valid_s1 && hold_next;

	// Advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold) begin
			valid_s1 <= prev.valid;
		end
	end

	// Rotate both vectors ahead of the payload register
	always_comb begin
		data_d = prev;
		data_d.a = rotate(prev.a);
		data_d.b = rotate(prev.b);
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (!hold) begin
			data_s1 <= data_d;
		end
	end

	always_comb begin
		beat = data_s1;
		beat.valid = valid_s1;
	end

endmodule

FILE: rtl/core/sva_tail.sv
module sva_tail (
	input  logic          clk,
	input  logic          arst_n,
	input  sva_pkg::beat_t prev,
	input  logic          fold,
	output logic          hold,
	sva_res_if.source     res
);

	logic valid_s1, valid_s2, valid_s3;
	logic hold_s1, hold_s2, hold_s3;
	logic neg_s1, neg_s2;
	logic zero_s1, zero_s2;
	logic signed [sva_pkg::ZW-1:0] diff_s1;
	logic [14:0] mag_s2;
	logic signed [15:0] angle_s3;
	logic zero_s3;

	logic signed [sva_pkg::ZW-1:0] diff;
	logic signed [sva_pkg::ZW-1:0] wrapped;
	logic signed [sva_pkg::ZW-1:0] absd;
	logic signed [sva_pkg::ZW-1:0] rsum;
	logic [sva_pkg::ZW-sva_pkg::FRAC_DROP-1:0] rounded;
	logic [14:0] capped;
	logic signed [15:0] signed_ang;
	logic signed [15:0] folded;

	// Stall chain from the output register back
	assign hold_s3 = valid_s3 && !res.ready;
	assign hold_s2 = valid_s2 && hold_s3;
	assign hold_s1 = valid_s1 && hold_s2;
	assign hold = hold_s1;

	// Difference of directions, wrapped into (-pi, pi]
	always_comb begin
		diff = prev.b.z - prev.a.z;
		if (diff > sva_pkg::PI_Q30) begin
			wrapped = diff - sva_pkg::TWO_PI_Q30;
		end else if (diff <= -sva_pkg::PI_Q30) begin
			wrapped = diff + sva_pkg::TWO_PI_Q30;
		end else begin
			wrapped = diff;
		end
	end

	// Magnitude, round to Q2.13, cap at pi
	always_comb begin
		absd = diff_s1[sva_pkg::ZW-1] ? -diff_s1 : diff_s1;
		rsum = absd + sva_pkg::ROUND_HALF;
		rounded = rsum[sva_pkg::ZW-1:sva_pkg::FRAC_DROP];
		if (rounded > {{(sva_pkg::ZW-sva_pkg::FRAC_DROP-15){1'b0}}, sva_pkg::PI_Q13_MAG}) begin
			capped = sva_pkg::PI_Q13_MAG;
		end else begin
			capped = rounded[14:0];
		end
	end

	// Apply sign rule, optional fold, zero override
	always_comb begin
		signed_ang = neg_s2 ? -$signed({1'b0, mag_s2}) : $signed({1'b0, mag_s2});
		folded = signed_ang;
		if (fold) begin
			if (signed_ang > sva_pkg::HALF_PI_Q13) begin
				folded = signed_ang - sva_pkg::PI_Q13;
			end else if (signed_ang < -sva_pkg::HALF_PI_Q13) begin
				folded = signed_ang + sva_pkg::PI_Q13;
			end
		end
		if (zero_s2) begin
			folded = '0;
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (!hold_s1) begin
				valid_s1 <= prev.valid;
			end
			if (!hold_s2) begin
				valid_s2 <= valid_s1;
			end
			if (!hold_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (!hold_s1) begin
			diff_s1 <= wrapped;
			neg_s1 <= prev.neg;
			zero_s1 <= prev.zero;
		end
		if (!hold_s2) begin
			mag_s2 <= capped;
			neg_s2 <= neg_s1;
			zero_s2 <= zero_s1;
		end
		if (!hold_s3) begin
			angle_s3 <= folded;
			zero_s3 <= zero_s2;
		end
	end

	assign res.valid = valid_s3;
	assign res.angle_rad = angle_s3;
	assign res.zero_vector = zero_s3;

endmodule

FILE: rtl/core/signed_vector_angle_unit.sv
// Signed angle between two 2-D vectors.
// Channels: vec carries one beat of (first_x, first_y, second_x, second_y),
// signed COMPONENT_WIDTH bits each; res returns angle_rad (signed Q2.13,
// pi = 25736) and zero_vector; cfg writes fold_mode (1 folds the result into
// -pi/2 .. pi/2 by adding or subtracting pi). cfg is always ready; write it
// only while no beat is in flight.
// Path from input accept to res.valid: the front register, the normalize
// cells, the CORDIC cells and the tail registers, which every beat walks
// through, one cell per cycle while res.ready stays high.
// Throughput: one beat per cycle while res.ready stays high; every cell is a register stage.
// Stalls: when res.ready is low the output register holds its beat; earlier
// stages keep filling empty slots, and vec.ready falls only once every stage
// holds a beat.
// Reset (arst_n low): all valid bits clear, fold_mode returns to 0; no
// result is pending after reset.
// A beat with either vector equal to (0,0) returns angle 0, zero_vector 1.
`include "signed_vector_angle_unit_assert.svh"

module signed_vector_angle_unit #(
	parameter int COMPONENT_WIDTH = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	sva_cfg_if.sink   cfg,
	sva_vec_if.sink   vec,
	sva_res_if.source res
);

	localparam int ROW_LEN = sva_pkg::NORM_STEPS + CORDIC_STAGES;
	localparam int XW = sva_pkg::XW;

	sva_pkg::beat_t chain [ROW_LEN+1];
	logic hold_c [ROW_LEN+2];

	logic fold_q;
	logic front_v_s1;
	sva_pkg::beat_t front_s1;
	sva_pkg::beat_t front_d;

	logic signed [XW-1:0] ax, ay, bx, by;

	// Magnitude, larger component and quarter-turn pre-rotation
	function automatic sva_pkg::vec_t front_vec(input logic signed [XW-1:0] x,
			input logic signed [XW-1:0] y);
		sva_pkg::vec_t r;
		logic signed [XW-1:0] mx;
		logic signed [XW-1:0] my;
		begin
			mx = x[XW-1] ? -x : x;
			my = y[XW-1] ? -y : y;
			r.m = (mx > my) ? mx[sva_pkg::MW-1:0] : my[sva_pkg::MW-1:0];
			if (x[XW-1]) begin
				if (!y[XW-1]) begin
					r.x = y;
					r.y = -x;
					r.z = sva_pkg::HALF_PI_Q30;
				end else begin
					r.x = -y;
					r.y = x;
					r.z = -sva_pkg::HALF_PI_Q30;
				end
			end else begin
				r.x = x;
				r.y = y;
				r.z = '0;
			end
			return r;
		end
	endfunction

	// Configuration register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			fold_q <= cfg.fold_mode;
		end
	end

	// Sign-extend components to the internal width
	assign ax = {{(XW-COMPONENT_WIDTH){vec.first_x[COMPONENT_WIDTH-1]}}, vec.first_x};
	assign ay = {{(XW-COMPONENT_WIDTH){vec.first_y[COMPONENT_WIDTH-1]}}, vec.first_y};
	assign bx = {{(XW-COMPONENT_WIDTH){vec.second_x[COMPONENT_WIDTH-1]}}, vec.second_x};
	assign by = {{(XW-COMPONENT_WIDTH){vec.second_y[COMPONENT_WIDTH-1]}}, vec.second_y};

	// Build the front beat
	always_comb begin
		front_d.valid = vec.valid;
		front_d.neg = ay[XW-1];
		front_d.zero = ((ax == '0) && (ay == '0)) || ((bx == '0) && (by == '0));
		front_d.a = front_vec(ax, ay);
		front_d.b = front_vec(bx, by);
	end

	// Front stage: accept when not stalled
	assign hold_c[0] = front_v_s1 && hold_c[1];
	assign vec.ready = !hold_c[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_v_s1 <= 1'b0;
		end else if (!hold_c[0]) begin
			front_v_s1 <= vec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold_c[0]) begin
			front_s1 <= front_d;
		end
	end

	always_comb begin
		chain[0] = front_s1;
		chain[0].valid = front_v_s1;
	end

	// Normalize cells: shift by 16, 8, 4, 2, 1
	for (genvar k = 0; k < sva_pkg::NORM_STEPS; k++) begin : g_norm
		sva_norm_cell #(
			.SHIFT(1 << (sva_pkg::NORM_STEPS - 1 - k))
		) u_norm (
			.clk      (clk),
			.arst_n   (arst_n),
			.prev     (chain[k]),
			.hold_next(hold_c[k+2]),
			.beat     (chain[k+1]),
			.hold     (hold_c[k+1])
		);
	end

	// CORDIC cells, one micro-rotation each
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		sva_cordic_cell #(
			.STAGE(i)
		) u_cordic (
			.clk      (clk),
			.arst_n   (arst_n),
			.prev     (chain[sva_pkg::NORM_STEPS+i]),
			.hold_next(hold_c[sva_pkg::NORM_STEPS+i+2]),
			.beat     (chain[sva_pkg::NORM_STEPS+i+1]),
			.hold     (hold_c[sva_pkg::NORM_STEPS+i+1])
		);
	end

	// Wrap, round, sign, fold and output register
	sva_tail u_tail (
		.clk   (clk),
		.arst_n(arst_n),
		.prev  (chain[ROW_LEN]),
		.fold  (fold_q),
		.hold  (hold_c[ROW_LEN+1]),
		.res   (res)
	);

	// A stalled input means a stalled, full output
	`SVA_ASSERT_NOW(a_ready_only_on_stall, clk, arst_n, !vec.ready, res.valid && !res.ready)
	// Zero vectors force the angle to zero
	`SVA_ASSERT_NOW(a_zero_angle, clk, arst_n, res.valid && res.zero_vector, res.angle_rad == '0)
	// Angle stays within plus or minus pi
	`SVA_ASSERT_NOW(a_angle_range, clk, arst_n, res.valid,
		(res.angle_rad <= sva_pkg::PI_Q13) && (res.angle_rad >= -sva_pkg::PI_Q13))
	// Folded results stay within plus or minus half pi
	`SVA_ASSERT_NOW(a_fold_range, clk, arst_n, res.valid && fold_q,
		(res.angle_rad <= sva_pkg::HALF_PI_Q13) && (res.angle_rad >= -sva_pkg::HALF_PI_Q13))
	// A held front beat keeps its payload
	`SVA_ASSERT_NEXT(a_front_hold, clk, arst_n, hold_c[0], $stable(front_s1))

endmodule
